>>> rtl/gasa_pkg.sv
// Shared types, codes and score arithmetic for the global alignment score array.
// Depends on nothing; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package gasa_pkg;

    // Score as carried on the result port and inside every cell.
    localparam int SCORE_W = 20;
    // One add of a score and an 8-bit operand, with headroom for the clamp.
    localparam int SUM_W   = 22;

    typedef logic signed [SCORE_W-1:0] t_score;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [7:0]         t_weight;
    typedef logic [7:0]                t_symbol;

    localparam t_sum SUM_MAX = t_sum'(524287);
    localparam t_sum SUM_MIN = t_sum'(-524288);

    // Request type codes.
    localparam logic REQ_QUERY   = 1'b0;
    localparam logic REQ_SUBJECT = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MATCH    = 2'd0;
    localparam logic [1:0] CFG_MISMATCH = 2'd1;
    localparam logic [1:0] CFG_GAP      = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SAT   = 2'd1;
    localparam logic [1:0] STATUS_LONG  = 2'd2;

    // Scoring weights broadcast to all cells.
    typedef struct packed {
        t_weight match_score;
        t_weight mismatch_score;
        t_weight gap_score;
    } t_cfg;

    // Wavefront token passed from cell to cell.
    // diag: previous column value of the row above (or its rebuilt value).
    // up:   new column value of the row above.
    typedef struct packed {
        logic    valid;
        logic    start;
        t_symbol sym;
        t_score  diag;
        t_score  up;
        logic    sat;
    } t_token;

    // Clamp a wide sum into the score range.
    function automatic t_score clamp_score(input t_sum v);
        t_score r;
        if (v > SUM_MAX) begin
            r = t_score'(SUM_MAX);
        end else if (v < SUM_MIN) begin
            r = t_score'(SUM_MIN);
        end else begin
            r = t_score'(v);
        end
        return r;
    endfunction

    // True when the clamp above changes the value.
    function automatic logic is_clamped(input t_sum v);
        return (v > SUM_MAX) || (v < SUM_MIN);
    endfunction

endpackage

>>> rtl/gasa_cell.sv
// One row of the alignment matrix: holds one query symbol and one column score.
// Depends on gasa_pkg for the token, weight and clamp definitions.
`timescale 1ns / 1ps

module gasa_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_head,
    input  gasa_pkg::t_token  i_inj,
    input  gasa_pkg::t_token  i_prev,
    input  gasa_pkg::t_cfg    i_cfg,
    input  logic              i_shift,
    input  gasa_pkg::t_symbol i_sym_next,
    output gasa_pkg::t_symbol o_sym,
    output gasa_pkg::t_token  o_tok
);
    import gasa_pkg::*;

    t_symbol r_sym;
    t_score  r_col;
    t_token  r_tok;

    t_token  tok_in;
    t_sum    init_sum;
    t_score  left;
    t_sum    diag_sum;
    t_sum    left_sum;
    t_sum    up_sum;
    t_sum    best;
    t_score  cell_val;
    logic    cell_sat;

    // The head cell takes the injected token, all others take their neighbor's.
    assign tok_in = i_head ? i_inj : i_prev;

    // Cell update: rebuild the column entry on a new subject, then take the
    // best of the diagonal, left and upper moves.
    always_comb begin
        init_sum = t_sum'(tok_in.diag) + t_sum'(i_cfg.gap_score);
        left     = tok_in.start ? clamp_score(init_sum) : r_col;
        diag_sum = t_sum'(tok_in.diag)
                 + t_sum'((r_sym == tok_in.sym) ? i_cfg.match_score : i_cfg.mismatch_score);
        left_sum = t_sum'(left) + t_sum'(i_cfg.gap_score);
        up_sum   = t_sum'(tok_in.up) + t_sum'(i_cfg.gap_score);
        best     = diag_sum;
        if (left_sum > best) begin
            best = left_sum;
        end
        if (up_sum > best) begin
            best = up_sum;
        end
        cell_val = clamp_score(best);
        cell_sat = tok_in.sat | is_clamped(best) | (tok_in.start & is_clamped(init_sum));
    end

    // Query symbols shift toward the head; the token moves toward the tail.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok.valid <= tok_in.valid;
        end
        if (i_shift) begin
            r_sym <= i_sym_next;
        end
        if (i_adv) begin
            r_tok.start <= tok_in.start;
            r_tok.sym   <= tok_in.sym;
            r_tok.diag  <= left;
            r_tok.up    <= cell_val;
            r_tok.sat   <= cell_sat;
            if (tok_in.valid) begin
                r_col <= cell_val;
            end
        end
    end

    assign o_sym = r_sym;
    assign o_tok = r_tok;

endmodule

>>> rtl/gasa_ctrl.sv
// Control for the score array: configuration registers, query length, row-0
// boundary, token injection and the result register. Depends on gasa_pkg.
`timescale 1ns / 1ps

module gasa_ctrl #(
    parameter int MAX_QUERY_LEN = 256,
    parameter int LEN_W         = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic              i_restart,
    input  gasa_pkg::t_symbol i_symbol,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gasa_pkg::t_score  o_score,
    output logic [1:0]        o_status,
    output gasa_pkg::t_cfg    o_cfg,
    output logic [LEN_W-1:0]  o_len,
    output logic              o_shift,
    output gasa_pkg::t_token  o_inj,
    output logic              o_adv,
    input  gasa_pkg::t_token  i_tail
);
    import gasa_pkg::*;

    t_cfg             r_cfg;
    logic [LEN_W-1:0] r_len;
    logic             r_too_long;
    logic             r_live;
    logic             r_sat;
    t_score           r_top;
    logic             r_busy;
    t_token           r_inj;
    logic             r_pend;
    t_score           r_pend_score;
    logic             r_out_valid;
    t_score           r_score;
    logic [1:0]       r_status;

    logic             accept;
    logic             acc_query;
    logic             acc_subject;
    logic [LEN_W-1:0] len_base;
    logic             has_room;
    logic             start;
    t_score           diag0;
    t_sum             top_sum;
    t_score           new_top;
    logic             cand_valid;
    t_score           cand_score;
    logic             cand_sat;
    logic             load;

    assign o_in_ready  = !r_busy;
    assign accept      = i_in_valid && !r_busy;
    assign acc_query   = accept && (i_req_type == REQ_QUERY);
    assign acc_subject = accept && (i_req_type == REQ_SUBJECT);

    // Query loading: a restart empties the query before the symbol is stored.
    assign len_base = i_restart ? '0 : r_len;
    assign has_room = len_base < LEN_W'(MAX_QUERY_LEN);
    assign o_shift  = acc_query && has_room;

    // Row-0 boundary step; a new subject begins from a zero corner.
    assign start   = i_restart || !r_live;
    assign diag0   = start ? '0 : r_top;
    assign top_sum = t_sum'(diag0) + t_sum'(r_cfg.gap_score);
    assign new_top = clamp_score(top_sum);

    // Result source: the tail of the chain, or the boundary for an empty query.
    assign cand_valid = r_pend || i_tail.valid;
    assign cand_score = r_pend ? r_pend_score : i_tail.up;
    assign cand_sat   = r_sat | (i_tail.valid & i_tail.sat);
    assign load       = cand_valid && (!r_out_valid || i_out_ready);
    assign o_adv      = !(i_tail.valid && !load);

    // Configuration, sequencing and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_score    <= t_weight'(1);
            r_cfg.mismatch_score <= t_weight'(-1);
            r_cfg.gap_score      <= t_weight'(-1);
            r_len                <= '0;
            r_too_long           <= 1'b0;
            r_live               <= 1'b0;
            r_sat                <= 1'b0;
            r_top                <= '0;
            r_busy               <= 1'b0;
            r_inj.valid          <= 1'b0;
            r_pend               <= 1'b0;
            r_out_valid          <= 1'b0;
        end else begin
            r_inj.valid <= 1'b0;

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MATCH:    r_cfg.match_score    <= t_weight'(i_cfg_data);
                    CFG_MISMATCH: r_cfg.mismatch_score <= t_weight'(i_cfg_data);
                    CFG_GAP:      r_cfg.gap_score      <= t_weight'(i_cfg_data);
                    default: begin
                    end
                endcase
            end

            if (acc_query) begin
                r_live <= 1'b0;
                if (has_room) begin
                    r_len      <= len_base + LEN_W'(1);
                    r_too_long <= i_restart ? 1'b0 : r_too_long;
                end else begin
                    r_len      <= len_base;
                    r_too_long <= 1'b1;
                end
            end

            if (acc_subject) begin
                r_live <= 1'b1;
                r_top  <= new_top;
                r_sat  <= (start ? 1'b0 : r_sat) | is_clamped(top_sum);
                r_busy <= 1'b1;
                if (r_len == '0) begin
                    r_pend       <= 1'b1;
                    r_pend_score <= new_top;
                end else begin
                    r_inj.valid <= 1'b1;
                    r_inj.start <= start;
                    r_inj.sym   <= i_symbol;
                    r_inj.diag  <= diag0;
                    r_inj.up    <= new_top;
                    r_inj.sat   <= 1'b0;
                end
            end

            if (load) begin
                r_out_valid <= 1'b1;
                r_score     <= cand_score;
                r_status    <= r_too_long ? STATUS_LONG : (cand_sat ? STATUS_SAT : STATUS_OK);
                r_sat       <= cand_sat;
                r_pend      <= 1'b0;
                r_busy      <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_score     = r_score;
    assign o_status    = r_status;
    assign o_cfg       = r_cfg;
    assign o_len       = r_len;
    assign o_inj       = r_inj;

endmodule

>>> rtl/global_alignment_score_array_unit.sv
// Top level of the global alignment score array: controller plus a chain of
// MAX_QUERY_LEN cells. Depends on gasa_pkg, gasa_ctrl and gasa_cell.
`timescale 1ns / 1ps

// Global (Needleman-Wunsch) alignment scoring with a linear gap penalty.
// Query symbols are loaded one per item and shift into a chain of
// MAX_QUERY_LEN cells from the tail end, so a query of length L sits in the
// last L cells. Each subject item sends one wavefront token down the chain
// from the first query cell to the tail, one cell per cycle unless a full
// result register stalls it, and the score of the whole query against the
// subject prefix leaves from the tail. A subject item passes through the
// injection register, L cells and the result register; the next item is taken
// once the result is in the output register. Symbols past MAX_QUERY_LEN are
// dropped and flagged with status 2 until the next query restart; a clamped
// score is flagged with status 1 for the rest of the subject.

module global_alignment_score_array_unit #(
    parameter int MAX_QUERY_LEN = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic         i_req_type,
    input  logic [7:0]   i_symbol,
    input  logic         i_restart,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic signed [19:0] o_score,
    output logic [1:0]   o_status
);
    import gasa_pkg::*;

    localparam int LEN_W = $clog2(MAX_QUERY_LEN + 1);

    t_cfg             cfg;
    logic [LEN_W-1:0] len;
    logic             shift;
    t_token           inj;
    logic             adv;
    t_token           tok  [MAX_QUERY_LEN];
    t_symbol          sym  [MAX_QUERY_LEN];

    gasa_ctrl #(
        .MAX_QUERY_LEN (MAX_QUERY_LEN),
        .LEN_W         (LEN_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_restart   (i_restart),
        .i_symbol    (i_symbol),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_score     (o_score),
        .o_status    (o_status),
        .o_cfg       (cfg),
        .o_len       (len),
        .o_shift     (shift),
        .o_inj       (inj),
        .o_adv       (adv),
        .i_tail      (tok[MAX_QUERY_LEN-1])
    );

    // Cell chain: cell k is the first query row when the query length
    // equals MAX_QUERY_LEN - k.
    for (genvar k = 0; k < MAX_QUERY_LEN; k++) begin : g_cell
        localparam logic [LEN_W-1:0] HEAD_LEN = LEN_W'(MAX_QUERY_LEN - k);

        t_token  prev;
        t_symbol sym_next;
        logic    head;

        if (k == 0) begin : g_first
            assign prev = '0;
        end else begin : g_inner
            assign prev = tok[k-1];
        end

        if (k == MAX_QUERY_LEN - 1) begin : g_last
            assign sym_next = i_symbol;
        end else begin : g_body
            assign sym_next = sym[k+1];
        end

        assign head = (len == HEAD_LEN);

        gasa_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (adv),
            .i_head     (head),
            .i_inj      (inj),
            .i_prev     (prev),
            .i_cfg      (cfg),
            .i_shift    (shift),
            .i_sym_next (sym_next),
            .o_sym      (sym[k]),
            .o_tok      (tok[k])
        );
    end

endmodule

>>> test/alignment_score_checker.sv
// Result checker for the global alignment score array: tracks configuration
// writes and accepted items, predicts each score and compares it with the output.
// Depends on gasa_pkg for the score types and the request, register and status codes.
`timescale 1ns / 1ps

module alignment_score_checker #(
    parameter int MAX_QUERY_LEN = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic             i_req_type,
    input  logic [7:0]       i_symbol,
    input  logic             i_restart,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  gasa_pkg::t_score i_score,
    input  logic [1:0]       i_status,
    output int               o_errors,
    output int               o_pending
);
    import gasa_pkg::*;

    localparam t_sum SCORE_HI = t_sum'(524287);
    localparam t_sum SCORE_LO = t_sum'(-524288);
    localparam int   REPORT_LIMIT = 10;

    typedef struct packed {
        t_score     score;
        logic [1:0] status;
    } t_alignment_result;

    // Scoring weights as last written.
    t_weight match_w;
    t_weight mismatch_w;
    t_weight gap_w;

    // Query symbols, the current DP column and the per-subject flags.
    t_symbol query_mem [MAX_QUERY_LEN];
    int      query_len;
    t_score  column [0:MAX_QUERY_LEN];
    t_score  top_row;
    logic    column_live;
    logic    query_overflow;
    logic    score_clamped;

    t_alignment_result expected_scores [$];
    int error_count;
    int result_index;

    assign o_errors  = error_count;
    assign o_pending = expected_scores.size();

    // Clamp a sum into the score range and remember that it happened.
    function automatic t_score limit_score(input t_sum v);
        t_score r;
        if (v > SCORE_HI) begin
            score_clamped = 1'b1;
            r = t_score'(SCORE_HI);
        end else if (v < SCORE_LO) begin
            score_clamped = 1'b1;
            r = t_score'(SCORE_LO);
        end else begin
            r = t_score'(v);
        end
        return r;
    endfunction

    // Advance the DP column by one subject symbol and return the full-query score.
    function automatic t_alignment_result score_subject_symbol(input t_symbol sym,
                                                               input logic fresh);
        t_alignment_result r;
        t_score diag;
        t_score left;
        t_sum   best;
        t_sum   cand;
        int     i;
        // A new subject rebuilds the column from the gap penalty alone.
        if (fresh || !column_live) begin
            score_clamped = 1'b0;
            top_row = '0;
            column[0] = '0;
            for (i = 1; i <= query_len; i++) begin
                column[i] = limit_score(t_sum'(column[i-1]) + t_sum'(gap_w));
            end
            column_live = 1'b1;
        end
        diag = top_row;
        top_row = limit_score(t_sum'(top_row) + t_sum'(gap_w));
        column[0] = top_row;
        for (i = 1; i <= query_len; i++) begin
            left = column[i];
            best = t_sum'(diag) +
                   t_sum'((query_mem[i-1] == sym) ? match_w : mismatch_w);
            cand = t_sum'(left) + t_sum'(gap_w);
            if (cand > best) begin
                best = cand;
            end
            cand = t_sum'(column[i-1]) + t_sum'(gap_w);
            if (cand > best) begin
                best = cand;
            end
            column[i] = limit_score(best);
            diag = left;
        end
        r.score  = column[query_len];
        r.status = query_overflow ? STATUS_LONG : (score_clamped ? STATUS_SAT : STATUS_OK);
        return r;
    endfunction

    // Watch all three ports at each rising edge.
    always @(posedge i_clk) begin : watch
        t_alignment_result want;
        if (!i_rst_n) begin
            match_w        = 8'sd1;
            mismatch_w     = -8'sd1;
            gap_w          = -8'sd1;
            query_len      = 0;
            top_row        = '0;
            column_live    = 1'b0;
            query_overflow = 1'b0;
            score_clamped  = 1'b0;
            error_count    = 0;
            result_index   = 0;
            expected_scores.delete();
        end else begin
            // Compare an accepted result with the oldest expectation.
            if (i_out_valid && i_out_ready) begin
                if (expected_scores.size() == 0) begin
                    if (error_count < REPORT_LIMIT) begin
                        $display("result %0d: unexpected, score %0d status %0d",
                                 result_index, i_score, i_status);
                    end
                    error_count++;
                end else begin
                    want = expected_scores.pop_front();
                    if (i_score !== want.score || i_status !== want.status) begin
                        if (error_count < REPORT_LIMIT) begin
                            $display({"result %0d: expected score %0d status %0d, ",
                                      "got score %0d status %0d"},
                                     result_index, want.score, want.status,
                                     i_score, i_status);
                        end
                        error_count++;
                    end
                end
                result_index++;
            end

            // Configuration writes take effect at once.
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MATCH:    match_w    = t_weight'(i_cfg_data);
                    CFG_MISMATCH: mismatch_w = t_weight'(i_cfg_data);
                    CFG_GAP:      gap_w      = t_weight'(i_cfg_data);
                    default: ;
                endcase
            end

            // An accepted item either extends the query or scores a subject symbol.
            if (i_in_valid && i_in_ready) begin
                if (i_req_type == REQ_QUERY) begin
                    if (i_restart) begin
                        query_len = 0;
                        query_overflow = 1'b0;
                    end
                    column_live = 1'b0;
                    if (query_len < MAX_QUERY_LEN) begin
                        query_mem[query_len] = i_symbol;
                        query_len++;
                    end else begin
                        query_overflow = 1'b1;
                    end
                end else begin
                    expected_scores.push_back(score_subject_symbol(i_symbol, i_restart));
                end
            end
        end
    end

endmodule

>>> test/tb_top.sv
// Top of the global alignment score array testbench: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on gasa_pkg, the block and alignment_score_checker.
`timescale 1ns / 1ps

module tb_top;
    import gasa_pkg::*;

    localparam int MAX_QUERY_LEN = 256;
    localparam int LIMIT         = 1000000;
    localparam int HOLD_CYCLES   = 600;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = CFG_MATCH;
    logic [7:0] cfg_data = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       req_type = REQ_QUERY;
    logic [7:0] symbol = 8'h00;
    logic       restart = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_score     score;
    logic [1:0] status;

    int errors;
    int pending;
    int cycle_count = 0;
    int burst_left = 0;
    int hold_requests = 0;

    global_alignment_score_array_unit #(
        .MAX_QUERY_LEN(MAX_QUERY_LEN)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_req_type  (req_type),
        .i_symbol    (symbol),
        .i_restart   (restart),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_score     (score),
        .o_status    (status)
    );

    alignment_score_checker #(
        .MAX_QUERY_LEN(MAX_QUERY_LEN)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_req_type  (req_type),
        .i_symbol    (symbol),
        .i_restart   (restart),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_score     (score),
        .i_status    (status),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Clock with an 8 ns period.
    always #4 clk = ~clk;

    // Abort a run that hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: a stall pattern chosen at random for each span, plus long
    // hold-offs on request from the stimulus.
    initial begin : receiver_pattern
        int mode;
        int span;
        int step;
        int holds_served;
        holds_served = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(32, 256);
            for (step = 0; step < span; step++) begin
                @(negedge clk);
                if (hold_requests != holds_served) begin
                    holds_served = hold_requests;
                    out_ready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (mode)
                    0:       out_ready = 1'b1;
                    1:       out_ready = 1'($urandom_range(0, 1));
                    2:       out_ready = ($urandom_range(0, 3) == 0);
                    default: out_ready = ((step % 6) < 2);
                endcase
            end
        end
    end

    // Offer one item and hold it until accepted. Starts and ends at a falling
    // edge; valid is left high for the next item.
    task automatic send_item(input logic req, input logic [7:0] sym, input logic rst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid = 1'b1;
        req_type = req;
        symbol   = sym;
        restart  = rst;
        do begin
            @(posedge clk);
        end while (!in_ready);
        @(negedge clk);
    endtask

    // Stop sending, let every expected result arrive, then let a query load settle.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (MAX_QUERY_LEN + 4) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] index, input logic [7:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_weights(input logic [7:0] m, input logic [7:0] mm, input logic [7:0] g);
        wait_idle();
        write_cfg(CFG_MATCH, m);
        write_cfg(CFG_MISMATCH, mm);
        write_cfg(CFG_GAP, g);
    endtask

    // A symbol from a window of the alphabet; narrow windows give many matches.
    function automatic logic [7:0] pick_symbol(input int base, input int span);
        return 8'((base + $urandom_range(0, span - 1)) % 256);
    endfunction

    // Mostly well-formed query loads followed by subjects, with some noise items.
    task automatic random_phase(input int n_items);
        int sent;
        int qlen;
        int slen;
        int n_subj;
        int base;
        int span;
        int s;
        int k;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                sent++;
            end else begin
                qlen = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64)
                                                     : $urandom_range(1, 12);
                base = $urandom_range(0, 255);
                span = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 4);
                for (k = 0; k < qlen; k++) begin
                    send_item(REQ_QUERY, pick_symbol(base, span), k == 0);
                end
                sent += qlen;
                n_subj = $urandom_range(1, 3);
                for (s = 0; s < n_subj; s++) begin
                    slen = $urandom_range(1, 16);
                    for (k = 0; k < slen; k++) begin
                        send_item(REQ_SUBJECT, pick_symbol(base, span),
                                  (k == 0) && (s > 0 || $urandom_range(0, 1) == 1));
                    end
                    sent += slen;
                end
            end
        end
    endtask

    initial begin : stimulus
        int k;
        int p;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Empty query with the reset weights; the first item starts a subject by itself.
        send_item(REQ_SUBJECT, 8'h00, 1'b0);
        send_item(REQ_SUBJECT, 8'hFF, 1'b0);
        send_item(REQ_SUBJECT, 8'h3C, 1'b1);
        send_item(REQ_SUBJECT, 8'hC3, 1'b0);

        // Extreme weights with a short query: match, mismatch, subject restarts
        // and a query append that forces a new subject.
        set_weights(8'h7F, 8'h80, 8'h00);
        send_item(REQ_QUERY, 8'h00, 1'b1);
        send_item(REQ_QUERY, 8'hFF, 1'b0);
        send_item(REQ_QUERY, 8'h5A, 1'b0);
        send_item(REQ_SUBJECT, 8'h00, 1'b1);
        send_item(REQ_SUBJECT, 8'hFF, 1'b0);
        send_item(REQ_SUBJECT, 8'h5A, 1'b0);
        send_item(REQ_SUBJECT, 8'hA5, 1'b0);
        send_item(REQ_QUERY, 8'h00, 1'b0);
        send_item(REQ_SUBJECT, 8'hFF, 1'b0);
        send_item(REQ_SUBJECT, 8'h00, 1'b1);
        send_item(REQ_QUERY, 8'hFF, 1'b1);
        send_item(REQ_SUBJECT, 8'hFF, 1'b0);

        // Query overflow: a full query plus dropped symbols, then a restart clears it.
        set_weights(8'h03, 8'hFE, 8'hFD);
        for (k = 0; k <= MAX_QUERY_LEN; k++) begin
            send_item(REQ_QUERY, 8'($urandom_range(0, 255)), k == 0);
        end
        for (k = 0; k < 3; k++) begin
            send_item(REQ_SUBJECT, 8'($urandom_range(0, 255)), k == 0);
        end
        send_item(REQ_QUERY, 8'h11, 1'b0);
        send_item(REQ_SUBJECT, 8'h11, 1'b0);
        send_item(REQ_QUERY, 8'h22, 1'b1);
        send_item(REQ_QUERY, 8'h33, 1'b0);
        send_item(REQ_SUBJECT, 8'h22, 1'b0);
        send_item(REQ_SUBJECT, 8'h33, 1'b0);

        // Back-pressure: the receiver holds off while items keep coming, then
        // the sender pauses until every result is in.
        hold_requests++;
        for (k = 0; k < 40; k++) begin
            send_item(REQ_SUBJECT, 8'($urandom_range(8'h20, 8'h35)), 1'b0);
        end
        wait_idle();

        // Random traffic under several weight settings.
        for (p = 0; p < 8; p++) begin
            case (p)
                0:       set_weights(8'h7F, 8'h7F, 8'h7F);
                1:       set_weights(8'h80, 8'h80, 8'h80);
                2:       set_weights(8'h7F, 8'h80, 8'h80);
                3:       set_weights(8'h80, 8'h7F, 8'h7F);
                4:       set_weights(8'h01, 8'hFF, 8'hFF);
                default: set_weights(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)));
            endcase
            random_phase(200);
        end

        // Drain and give late or extra results time to show up.
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (MAX_QUERY_LEN + 8) @(negedge clk);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
